// File: design/rsm_pkg.sv
// Shared constants, types and helper functions for the rank/select multiset.
// No dependencies; imported by every module of the block.
`default_nettype none

package rsm_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IN_BITS    = 32;
    localparam int RANK_W     = 7;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CMP_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int GRP_SIZE   = 8;
    localparam int NUM_GRPS   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef logic [VALUE_BITS-1:0] val_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_BAD_RANK  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic             ins;
        logic             ext;
        val_t             new_val;
        logic [CMP_W-1:0] count;
        logic [CMP_W-1:0] rank;
    } ctrl_t;

    // Sign-extend the 32-bit input, then keep VALUE_BITS bits
    function automatic val_t widen_input(input logic [IN_BITS-1:0] raw);
        logic [63:0] w;
        w = {{(64-IN_BITS){raw[IN_BITS-1]}}, raw};
        return w[VALUE_BITS-1:0];
    endfunction

    // Stored value to the 32-bit output field (zero-extend or truncate)
    function automatic logic [IN_BITS-1:0] narrow_output(input val_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[IN_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/rsm_cell.sv
// One slot of the sorted chain: holds a value, decides locally whether to
// shift, take the new value or hold. Depends on rsm_pkg.
`default_nettype none

module rsm_cell
    import rsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] idx,
    input  wire ctrl_t            ctrl,
    input  wire val_t             prev_val,
    input  wire logic             prev_ins_here,
    input  wire val_t             next_val,
    output val_t                  val,
    output logic                  ins_here,
    output val_t                  sel_val
);

    val_t             val_reg;
    val_t             val_next;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] idx_plus;
    logic             occupied;
    logic             greater;

    assign idx_ext  = CMP_W'(idx);
    assign idx_plus = idx_ext + CMP_W'(1);
    assign occupied = idx_ext < ctrl.count;
    assign greater  = occupied && ($signed(val_reg) > $signed(ctrl.new_val));

    // insert point is at or before this cell
    assign ins_here = greater || !occupied;

    // extracted value leaves through the select tree
    assign sel_val = (idx_plus == ctrl.rank) ? val_reg : '0;

    // next value: shift up on insert, shift down on extract
    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins)
        begin
            if (prev_ins_here)
                val_next = prev_val;
            else if (ins_here)
                val_next = ctrl.new_val;
        end
        else if (ctrl.ext)
        begin
            if (idx_plus >= ctrl.rank)
                val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

// File: design/rsm_sel_tree.sv
// Registered OR tree that gathers the one selected cell value.
// Depends on rsm_pkg.
`default_nettype none

module rsm_sel_tree
    import rsm_pkg::*;
(
    input  wire logic clk,
    input  wire logic load,
    input  wire val_t sel [CAPACITY],
    output val_t      merged
);

    val_t grp_reg [NUM_GRPS];

    // first level: one register per group of cells
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NUM_GRPS; g++)
            begin
                val_t acc;
                acc = '0;
                for (int j = 0; j < GRP_SIZE; j++)
                begin
                    if (g * GRP_SIZE + j < CAPACITY)
                        acc = acc | sel[g * GRP_SIZE + j];
                end
                grp_reg[g] <= acc;
            end
        end
    end

    // second level: combine the group registers
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NUM_GRPS; g++)
            merged = merged | grp_reg[g];
    end

endmodule

`default_nettype wire

// File: design/rank_select_multiset_unit.sv
// Rank/select multiset: sorted chain of cells with insert and rank extract.
// Requests: a new one is taken only after the previous result has moved to
// the output register, which reads the extracted value out of the registered
// select tree; a stalled result holds off input.
// Reset (rst_n, async low) clears the item count and the handshake state;
// cell contents stay undefined until written.
`default_nettype none

module rank_select_multiset_unit
    import rsm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                cmd,
    input  wire logic [IN_BITS-1:0]  value,
    input  wire logic [RANK_W-1:0]   rank,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               status,
    output logic [IN_BITS-1:0]       result_value
);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               busy_reg;
    status_t            pend_status_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [IN_BITS-1:0] out_value_reg;

    logic               accept;
    logic               out_free;
    logic               ins_ok;
    logic               rank_ok;
    logic [CMP_W-1:0]   rank_ext;
    logic [CMP_W-1:0]   count_ext;
    status_t            req_status;
    ctrl_t              ctrl;
    val_t               merged;

    val_t               cell_val  [CAPACITY];
    val_t               cell_sel  [CAPACITY];
    logic               cell_ins  [CAPACITY];

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign out_free = !out_valid_reg || !out_stall;

    assign rank_ext  = CMP_W'(rank);
    assign count_ext = CMP_W'(count_reg);
    assign ins_ok    = (cmd == CMD_INSERT) && (count_reg != CNT_W'(CAPACITY));
    assign rank_ok   = (cmd == CMD_EXTRACT) && (rank_ext != '0) && (rank_ext <= count_ext);

    // request decode
    always_comb
    begin
        if (cmd == CMD_INSERT)
            req_status = ins_ok ? ST_INSERTED : ST_FULL;
        else
            req_status = rank_ok ? ST_EXTRACTED : ST_BAD_RANK;
    end

    // count update
    always_comb
    begin
        count_next = count_reg;
        if (accept && ins_ok)
            count_next = count_reg + CNT_W'(1);
        else if (accept && rank_ok)
            count_next = count_reg - CNT_W'(1);
    end

    // broadcast to the chain
    always_comb
    begin
        ctrl.ins     = accept && ins_ok;
        ctrl.ext     = accept && rank_ok;
        ctrl.new_val = widen_input(value);
        ctrl.count   = count_ext;
        ctrl.rank    = rank_ext;
    end

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        val_t prev_v;
        logic prev_h;
        val_t next_v;

        if (i == 0)
        begin : g_first
            assign prev_v = cell_val[i];
            assign prev_h = 1'b0;
        end
        else
        begin : g_mid
            assign prev_v = cell_val[i-1];
            assign prev_h = cell_ins[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_v = cell_val[i];
        end
        else
        begin : g_body
            assign next_v = cell_val[i+1];
        end

        rsm_cell u_cell (
            .clk           (clk),
            .idx           (IDX_W'(i)),
            .ctrl          (ctrl),
            .prev_val      (prev_v),
            .prev_ins_here (prev_h),
            .next_val      (next_v),
            .val           (cell_val[i]),
            .ins_here      (cell_ins[i]),
            .sel_val       (cell_sel[i])
        );
    end

    rsm_sel_tree u_tree (
        .clk    (clk),
        .load   (accept),
        .sel    (cell_sel),
        .merged (merged)
    );

    // control and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            busy_reg        <= 1'b0;
            pend_status_reg <= ST_INSERTED;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_INSERTED;
            out_value_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                busy_reg        <= 1'b1;
                pend_status_reg <= req_status;
            end
            if (busy_reg && out_free)
            begin
                busy_reg       <= 1'b0;
                out_valid_reg  <= 1'b1;
                out_status_reg <= pend_status_reg;
                out_value_reg  <= (pend_status_reg == ST_EXTRACTED) ?
                                  narrow_output(merged) : '0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_value = out_value_reg;

endmodule

`default_nettype wire

// File: design/rsm_checker.sv
// Port-level checks for rank_select_multiset_unit, bound to the top level.
// Depends on rsm_pkg.
`default_nettype none

module rsm_sva_checker
    import rsm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic [IN_BITS-1:0] result_value
);

    // one request in flight: stall follows every accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous one in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(result_value)))
        else $error("stalled result changed");

    // only an extract carries a value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_EXTRACTED)) |-> (result_value == '0))
        else $error("nonzero value on non-extract result");

    // handshake is idle once reset has been seen at an edge
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (!out_valid && !in_stall))
        else $error("handshake active during reset");

endmodule

bind rank_select_multiset_unit rsm_sva_checker u_rsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value)
);

`default_nettype wire

// File: tb/rsm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for rank_select_multiset_unit: keeps a sorted copy of the multiset,
// predicts one outcome per accepted request and checks every accepted result.
// Depends on rsm_pkg for widths and the status/command codes.

module rsm_checker
    import rsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                cmd,
    input  logic [IN_BITS-1:0]  value,
    input  logic [RANK_W-1:0]   rank,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          status,
    input  logic [IN_BITS-1:0]  result_value,
    output int                  mismatches,
    output int                  pending,
    output int                  stored
);

    typedef struct {
        status_t            status;
        logic [IN_BITS-1:0] value;
    } outcome_t;

    // Ascending by signed value, duplicates kept
    val_t     sorted_vals[$];
    outcome_t expected_outcomes[$];
    outcome_t want;

    // Apply one request to the shadow multiset and queue its outcome
    task automatic apply_request(input logic c, input logic [IN_BITS-1:0] raw,
                                 input logic [RANK_W-1:0] r);
        outcome_t o;
        val_t     v;
        int       pos;
        o.status = ST_INSERTED;
        o.value  = '0;
        v = val_t'($signed(raw));
        if (c == CMD_INSERT) begin
            if (sorted_vals.size() >= CAPACITY) begin
                o.status = ST_FULL;
            end
            else begin
                // new value goes after every entry not greater than it
                pos = 0;
                while (pos < sorted_vals.size() && $signed(sorted_vals[pos]) <= $signed(v))
                    pos++;
                sorted_vals.insert(pos, v);
            end
        end
        else if (r == 0 || r > sorted_vals.size()) begin
            o.status = ST_BAD_RANK;
        end
        else begin
            o.status = ST_EXTRACTED;
            o.value  = IN_BITS'(sorted_vals[r-1]);
            sorted_vals.delete(r - 1);
        end
        expected_outcomes.push_back(o);
    endtask

    // Results are checked before the same edge's request is applied;
    // latency rules out a same-edge result for it anyway.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding: status %0d value %h",
                                 $time, status, result_value);
                end
                else begin
                    want = expected_outcomes.pop_front();
                    if (status !== want.status || result_value !== want.value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: status exp %0d got %0d, value exp %h got %h",
                                     $time, want.status, status, want.value, result_value);
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_request(cmd, value, rank);
        end
        pending = expected_outcomes.size();
        stored  = sorted_vals.size();
    end

endmodule

// File: tb/rank_select_multiset_unit_test.sv
`timescale 1ns / 100ps
// Top of the rank_select_multiset_unit testbench: clock, reset, request and
// result-side traffic, watchdog and verdict. Depends on rsm_pkg and rsm_checker.

module rank_select_multiset_unit_test;
    import rsm_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1700;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                cmd;
    logic [IN_BITS-1:0]  value;
    logic [RANK_W-1:0]   rank;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic [IN_BITS-1:0]  result_value;

    int mismatches;
    int pending;
    int stored;

    // steady: no idle cycles on either side; hold_token bumps trigger a long hold-off
    bit steady;
    int hold_token;
    int hold_seen;
    int idle_cycles;
    int sent;
    int block_idx;
    int block_len;
    int ins_pct;
    bit is_ins;

    rank_select_multiset_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .rank         (rank),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_value (result_value)
    );

    rsm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .rank         (rank),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_value (result_value),
        .mismatches   (mismatches),
        .pending      (pending),
        .stored       (stored)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly valid ranks, plus zero, one past the count and anything at all
    function automatic logic [RANK_W-1:0] choose_rank();
        int n;
        int sel;
        n   = stored;
        sel = $urandom_range(99);
        if (sel < 75 && n > 0)
            return RANK_W'($urandom_range(1, n));
        if (sel < 82)
            return '0;
        if (sel < 90 && n < 127)
            return RANK_W'(n + 1);
        return RANK_W'($urandom_range(0, 127));
    endfunction

    // Full range, a narrow band for duplicates, the extremes and right-shifted randoms
    function automatic logic [IN_BITS-1:0] choose_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return IN_BITS'($urandom);
        if (sel < 70)
            return IN_BITS'($signed($urandom_range(0, 8)) - 4);
        if (sel < 85)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return IN_BITS'($urandom >> $urandom_range(0, 31));
    endfunction

    // Present one request at a falling edge, maybe after a gap, and wait for it
    // to be taken. Extract ranks are picked once the shadow count is settled.
    task automatic send_item(input cmd_t c, input logic [IN_BITS-1:0] v,
                             input logic [RANK_W-1:0] r, input bit pick_rank);
        int gap;
        @(negedge clk);
        if (!steady && $urandom_range(99) < 15)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        if (pick_rank)
            r = choose_rank();
        in_valid = 1'b1;
        cmd      = c;
        value    = v;
        rank     = r;
        do @(posedge clk); while (in_stall);
    endtask

    // Result side: random stalls, long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall = !steady && ($urandom_range(99) < 15);
        end
    end

    // Watchdog: cycles with no handshake on either channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("rank_select_multiset_unit regression: fail");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_INSERT;
        value    = '0;
        rank     = '0;
        steady   = 1'b0;
        hold_token = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty store, extremes, duplicates, bad ranks, stray fields
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd1,   1'b0);
        send_item(CMD_INSERT,  32'h0000_0000, 7'd0,   1'b0);
        send_item(CMD_INSERT,  32'h7FFF_FFFF, 7'd0,   1'b0);
        send_item(CMD_INSERT,  32'h8000_0000, 7'd0,   1'b0);
        send_item(CMD_INSERT,  32'hFFFF_FFFF, 7'd0,   1'b0);
        send_item(CMD_INSERT,  32'h0000_0000, 7'd0,   1'b0);
        send_item(CMD_INSERT,  32'h0000_0001, 7'd0,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd0,   1'b0);
        send_item(CMD_EXTRACT, 32'hFFFF_FFFF, 7'd127, 1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd7,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd6,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd1,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd2,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd2,   1'b0);
        send_item(CMD_INSERT,  32'h5555_5555, 7'd127, 1'b0);
        send_item(CMD_INSERT,  32'hAAAA_AAAA, 7'd64,  1'b0);
        send_item(CMD_EXTRACT, 32'h1234_5678, 7'd64,  1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd1,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd3,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd2,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd1,   1'b0);
        send_item(CMD_EXTRACT, 32'h0000_0000, 7'd1,   1'b0);

        // Random blocks with varying insert mix: fill past full, drain past empty
        sent      = 0;
        block_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (block_idx % 5)
                0: ins_pct = 50;
                1: ins_pct = 92;
                2: ins_pct = 15;
                3: ins_pct = 65;
                default: ins_pct = 35;
            endcase
            if (block_idx % 6 == 2)
                hold_token++;
            if (block_idx % 6 == 4)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                wait (pending == 0);
            end
            steady    = (block_idx % 6 == 0) && (block_idx > 0);
            block_len = $urandom_range(40, 120);
            repeat (block_len)
            begin
                is_ins = $urandom_range(99) < ins_pct;
                send_item(is_ins ? CMD_INSERT : CMD_EXTRACT, choose_value(),
                          RANK_W'($urandom_range(0, 127)), !is_ins);
                sent++;
            end
            steady = 1'b0;
            block_idx++;
        end

        // Drain and settle
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("rank_select_multiset_unit regression: pass");
        else
            $display("rank_select_multiset_unit regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/rsm_pkg.sv
design/rsm_cell.sv
design/rsm_sel_tree.sv
design/rank_select_multiset_unit.sv
design/rsm_checker.sv
tb/rsm_checker.sv
tb/rank_select_multiset_unit_test.sv
